// ----- rtl/triangle_plane_section_defines.svh -----
// Assertion macros used by the triangle plane section RTL.
`ifndef TRIANGLE_PLANE_SECTION_DEFINES_SVH
`define TRIANGLE_PLANE_SECTION_DEFINES_SVH
`ifndef SYNTH
`define TPS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tps: assertion failed");
`define TPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tps: implication failed");
`else
`define TPS_ASSERT(label, clk, rst_n, prop)
`define TPS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/tps_pkg.sv -----
package tps_pkg;

  localparam int CW       = 32;          // coordinate width
  localparam int NW       = 18;          // normal component width
  localparam int TW       = 16;          // tolerance width
  localparam int DIFW     = CW + 1;      // vertex minus origin
  localparam int PRODW    = DIFW + NW;   // one distance term
  localparam int SUMW     = PRODW + 2;   // sum of three terms
  localparam int DW       = 37;          // rounded distance, signed
  localparam int AW       = DW;          // distance magnitude
  localparam int SW       = AW + 1;      // divisor |da| + |db|
  localparam int QW       = 31;          // quotient bits
  localparam int OFFW     = DIFW + QW + 1;
  localparam int T_FRAC   = 30;
  localparam int DIV_STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES = (QW + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t [2:0] point_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_NORMAL_X   = 3'd3,
    REG_NORMAL_Y   = 3'd4,
    REG_NORMAL_Z   = 3'd5,
    REG_PLANE_TOL  = 3'd6,
    REG_POINT_TOL  = 3'd7
  } reg_e;

  // Partial state of one restoring division.
  typedef struct packed {
    logic [SW-1:0] rem;
    logic [SW-1:0] den;
    logic [QW-1:0] quo;
  } div_t;

endpackage

// ----- rtl/tps_div_stage.sv -----
module tps_div_stage import tps_pkg::*; #(
  parameter int STEPS = 4
) (
  input  logic clk_i,
  input  div_t div_i,
  output div_t div_o
);

  div_t div_d, div_q;

  always_comb begin
    logic [SW:0] sh;
    div_d = div_i;
    for (int k = 0; k < STEPS; k++) begin
      sh = {div_d.rem, 1'b0};
      if (sh >= {1'b0, div_d.den}) begin
        div_d.rem = SW'(sh - {1'b0, div_d.den});
        div_d.quo = {div_d.quo[QW-2:0], 1'b1};
      end else begin
        div_d.rem = sh[SW-1:0];
        div_d.quo = {div_d.quo[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign div_o = div_q;

endmodule

// ----- rtl/triangle_plane_section.sv -----
// Triangle plane section.
// A triangle is offered on the vert_*_i ports with start_i; it is taken at a
// clock edge where start_i is high and busy_o is low. busy_o stays low, so one
// triangle can be taken on every cycle.
// The pipeline has 17 register stages: distance (4), classification (1),
// crossing fraction by restoring division, up to four quotient bits a stage (8),
// crossing point multiply and round (2), and point deduplication (2).
// A segment appears on seg_*_o, registered in stage 16, with seg_valid_o high
// for one cycle. Triangles with fewer than two distinct points give no beat.
// The receiver cannot stall the block.
// Plane registers are written on the cfg_* channel; cfg_ready_o is always
// high. They should only change while no triangle is in flight.
// Reset clears the pipeline valid bits and loads the register defaults
// (normal along z, tolerances of one LSB).
`include "triangle_plane_section_defines.svh"
module triangle_plane_section import tps_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  input  logic signed [31:0] vert_a_x_i,
  input  logic signed [31:0] vert_a_y_i,
  input  logic signed [31:0] vert_a_z_i,
  input  logic signed [31:0] vert_b_x_i,
  input  logic signed [31:0] vert_b_y_i,
  input  logic signed [31:0] vert_b_z_i,
  input  logic signed [31:0] vert_c_x_i,
  input  logic signed [31:0] vert_c_y_i,
  input  logic signed [31:0] vert_c_z_i,
  output logic          seg_valid_o,
  output logic signed [31:0] seg_start_x_o,
  output logic signed [31:0] seg_start_y_o,
  output logic signed [31:0] seg_start_z_o,
  output logic signed [31:0] seg_end_x_o,
  output logic signed [31:0] seg_end_y_o,
  output logic signed [31:0] seg_end_z_o
);

  localparam int LAST = 15;

  // Configuration registers.
  coord_t                 org_q [3];
  logic signed [NW-1:0]   nrm_q [3];
  logic [TW-1:0]          ptol_q, pttol_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      nrm_q[0] <= '0;
      nrm_q[1] <= '0;
      nrm_q[2] <= NW'(65536);
      ptol_q   <= TW'(1);
      pttol_q  <= TW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_index_i))
        REG_ORIGIN_X:  org_q[0] <= cfg_data_i;
        REG_ORIGIN_Y:  org_q[1] <= cfg_data_i;
        REG_ORIGIN_Z:  org_q[2] <= cfg_data_i;
        REG_NORMAL_X:  nrm_q[0] <= cfg_data_i[NW-1:0];
        REG_NORMAL_Y:  nrm_q[1] <= cfg_data_i[NW-1:0];
        REG_NORMAL_Z:  nrm_q[2] <= cfg_data_i[NW-1:0];
        REG_PLANE_TOL: ptol_q   <= cfg_data_i[TW-1:0];
        REG_POINT_TOL: pttol_q  <= cfg_data_i[TW-1:0];
        default:       ptol_q   <= ptol_q;
      endcase
    end
  end

  // Valid bits per stage; payload pipelines.
  logic                    vld_q [LAST+1];
  coord_t [8:0]            vtx_q [15];
  logic [2:0]              on_q  [4:14];
  logic [2:0]              crs_q [4:14];
  logic signed [DIFW-1:0]  diff_q [9];
  logic signed [PRODW-1:0] prod_q [9];
  logic signed [DW-1:0]    dist_q [3];
  div_t                    div_s [DIV_STAGES+1][3];
  logic signed [OFFW-1:0]  off_q [9];
  coord_t                  pt_q [9];
  point_t                  cand_q [9];
  logic [8:0]              cok_q;
  point_t                  k0_q;
  logic                    k0_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LAST; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= start_i && !busy_o;
      for (int k = 1; k <= LAST; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Stages 0 to 3: plane distance of each vertex.
  coord_t [8:0]            vtx_in;
  logic signed [SUMW-1:0]  sum_w [3];
  logic signed [SUMW-1:0]  rnd_w [3];

  always_comb begin
    vtx_in[0] = vert_a_x_i;
    vtx_in[1] = vert_a_y_i;
    vtx_in[2] = vert_a_z_i;
    vtx_in[3] = vert_b_x_i;
    vtx_in[4] = vert_b_y_i;
    vtx_in[5] = vert_b_z_i;
    vtx_in[6] = vert_c_x_i;
    vtx_in[7] = vert_c_y_i;
    vtx_in[8] = vert_c_z_i;
    for (int i = 0; i < 3; i++) begin
      sum_w[i] = SUMW'(prod_q[i*3]) + SUMW'(prod_q[i*3+1]) + SUMW'(prod_q[i*3+2]);
      rnd_w[i] = sum_w[i] + SUMW'(1 <<< 15);
    end
  end

  always_ff @(posedge clk_i) begin
    vtx_q[0] <= vtx_in;
    for (int k = 1; k < 15; k++) vtx_q[k] <= vtx_q[k-1];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        diff_q[i*3+j] <= DIFW'($signed(vtx_q[0][i*3+j])) - DIFW'(org_q[j]);
        prod_q[i*3+j] <= PRODW'(diff_q[i*3+j]) * PRODW'(nrm_q[j]);
      end
      dist_q[i] <= DW'(rnd_w[i] >>> 16);
    end
  end

  // Stage 4: classify vertices and edges, seed the dividers.
  logic signed [DW-1:0] tol_w;
  logic [AW-1:0]        mag_w [3];
  logic [2:0]           on_w, crs_w;

  always_comb begin
    int n;
    tol_w = $signed({(DW-TW)'(0), ptol_q});
    for (int i = 0; i < 3; i++) begin
      on_w[i]  = (dist_q[i] >= -tol_w) && (dist_q[i] <= tol_w);
      mag_w[i] = dist_q[i] < 0 ? AW'(-dist_q[i]) : AW'(dist_q[i]);
    end
    for (int e = 0; e < 3; e++) begin
      n = (e == 2) ? 0 : e + 1;
      crs_w[e] = (dist_q[e] < -tol_w && dist_q[n] > tol_w) ||
                 (dist_q[e] > tol_w && dist_q[n] < -tol_w);
    end
  end

  always_ff @(posedge clk_i) begin
    on_q[4]  <= on_w;
    crs_q[4] <= crs_w;
    for (int k = 5; k <= 14; k++) begin
      on_q[k]  <= on_q[k-1];
      crs_q[k] <= crs_q[k-1];
    end
    for (int e = 0; e < 3; e++) begin
      div_s[0][e].rem <= SW'(mag_w[e]);
      div_s[0][e].den <= SW'(mag_w[e]) + SW'(mag_w[(e == 2) ? 0 : e + 1]);
      div_s[0][e].quo <= '0;
    end
  end

  // Stages 5 to 12: crossing fraction |da| / (|da| + |db|).
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    localparam int NSTEP = (QW - s * DIV_STEPS_PER_STAGE < DIV_STEPS_PER_STAGE) ?
                           QW - s * DIV_STEPS_PER_STAGE : DIV_STEPS_PER_STAGE;
    for (genvar e = 0; e < 3; e++) begin : g_edge
      tps_div_stage #(.STEPS(NSTEP)) u_stage (
        .clk_i (clk_i),
        .div_i (div_s[s][e]),
        .div_o (div_s[s+1][e])
      );
    end
  end

  // Stages 13 and 14: crossing point per edge and axis.
  logic [QW-1:0] t_w [3];

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      t_w[e] = QW'(({1'b0, div_s[DIV_STAGES][e].quo} + (QW+1)'(1)) >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < 3; e++) begin
      for (int j = 0; j < 3; j++) begin
        off_q[e*3+j] <= OFFW'(DIFW'($signed(vtx_q[12][((e == 2) ? 0 : e + 1)*3+j]))
                        - DIFW'($signed(vtx_q[12][e*3+j])))
                        * OFFW'($signed({1'b0, t_w[e]}));
        pt_q[e*3+j] <= CW'(OFFW'($signed(vtx_q[13][e*3+j]))
                       + ((off_q[e*3+j] + OFFW'(1 <<< (T_FRAC-1))) >>> T_FRAC));
      end
    end
  end

  // Stage 15: candidate list in edge order and the first kept point.
  point_t     cand_w [9];
  logic [8:0] cok_w;
  point_t     k0_w;
  logic       k0_ok_w;

  always_comb begin
    int n;
    for (int e = 0; e < 3; e++) begin
      n = (e == 2) ? 0 : e + 1;
      for (int j = 0; j < 3; j++) begin
        cand_w[e*3][j]   = vtx_q[14][e*3+j];
        cand_w[e*3+1][j] = vtx_q[14][n*3+j];
        cand_w[e*3+2][j] = pt_q[e*3+j];
      end
      cok_w[e*3]   = on_q[14][e];
      cok_w[e*3+1] = on_q[14][n];
      cok_w[e*3+2] = crs_q[14][e];
    end
    k0_w    = cand_w[0];
    k0_ok_w = 1'b0;
    for (int c = 0; c < 9; c++) begin
      if (cok_w[c] && !k0_ok_w) begin
        k0_w    = cand_w[c];
        k0_ok_w = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 9; c++) cand_q[c] <= cand_w[c];
    cok_q   <= cok_w;
    k0_q    <= k0_w;
    k0_ok_q <= k0_ok_w;
  end

  // Stage 16: the second point is the first candidate not close to the first.
  // The first point matches itself, so earlier candidates need no masking.
  point_t  k1_w;
  logic    k1_ok_w;
  logic [8:0] same_w;

  always_comb begin
    logic signed [DIFW-1:0] dv;
    logic [DIFW-1:0]        da;
    for (int c = 0; c < 9; c++) begin
      same_w[c] = 1'b1;
      for (int j = 0; j < 3; j++) begin
        dv = DIFW'($signed(cand_q[c][j])) - DIFW'($signed(k0_q[j]));
        da = dv < 0 ? DIFW'(-dv) : DIFW'(dv);
        if (da > DIFW'(pttol_q)) same_w[c] = 1'b0;
      end
    end
    k1_w    = cand_q[0];
    k1_ok_w = 1'b0;
    for (int c = 0; c < 9; c++) begin
      if (cok_q[c] && !same_w[c] && !k1_ok_w) begin
        k1_w    = cand_q[c];
        k1_ok_w = 1'b1;
      end
    end
  end

  logic seg_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_valid_q <= 1'b0;
    end else begin
      seg_valid_q <= vld_q[LAST] && k0_ok_q && k1_ok_w;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_start_x_o <= k0_q[0];
    seg_start_y_o <= k0_q[1];
    seg_start_z_o <= k0_q[2];
    seg_end_x_o   <= k1_w[0];
    seg_end_y_o   <= k1_w[1];
    seg_end_z_o   <= k1_w[2];
  end

  assign seg_valid_o = seg_valid_q;

  // A segment beat always traces back to a triangle taken through start_i.
  `TPS_ASSERT_IMPL(a_seg_origin, clk_i, rst_ni, seg_valid_o, $past(start_i && !busy_o, 17))
  // Crossing edge 0 never has an endpoint inside the tolerance band.
  `TPS_ASSERT_IMPL(a_cross_excl, clk_i, rst_ni, vld_q[4] && crs_q[4][0],
                   !on_q[4][0] && !on_q[4][1])
  // A beat needs a first point that was found.
  `TPS_ASSERT_IMPL(a_seg_k0, clk_i, rst_ni, seg_valid_o, $past(k0_ok_q))

endmodule

// ----- tb/tb_triangle_plane_section.sv -----
`timescale 1ns / 100ps

module tb_triangle_plane_section;
  import tps_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 30;
  localparam int RAND_PER_PHASE = 206;

  typedef coord_t [5:0] seg_t;  // start x, y, z, then end x, y, z
  typedef enum int {CHK_PREDICT, CHK_SEGMENT, CHK_NONE} chk_e;
  typedef struct {
    point_t a;
    point_t b;
    point_t c;
    chk_e chk;
    seg_t seg;
  } tri_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  point_t va = '0, vb = '0, vc = '0;
  logic seg_valid_o;
  seg_t seg_out;

  triangle_plane_section dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .vert_a_x_i(va[0]), .vert_a_y_i(va[1]), .vert_a_z_i(va[2]),
    .vert_b_x_i(vb[0]), .vert_b_y_i(vb[1]), .vert_b_z_i(vb[2]),
    .vert_c_x_i(vc[0]), .vert_c_y_i(vc[1]), .vert_c_z_i(vc[2]),
    .seg_valid_o,
    .seg_start_x_o(seg_out[0]), .seg_start_y_o(seg_out[1]), .seg_start_z_o(seg_out[2]),
    .seg_end_x_o(seg_out[3]), .seg_end_y_o(seg_out[4]), .seg_end_z_o(seg_out[5])
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Plane settings as the block should hold them.
  longint plane_org[3];
  longint plane_nrm[3];
  longint on_plane_tol;
  longint same_pt_tol;

  seg_t pending_segs[$];
  int errors = 0;
  int triangles_sent = 0;
  int segs_seen = 0;
  int cycle_count = 0;
  bit quiet_stretch = 1'b0;

  longint sec_pts[2][3];
  int sec_cnt;

  function automatic longint sext_to(longint v, int w);
    longint m;
    m = (longint'(1) << w) - 1;
    v = v & m;
    if (v >> (w - 1)) return v - (longint'(1) << w);
    return v;
  endfunction

  function automatic void store_reg(reg_e idx, logic [31:0] data);
    case (idx)
      REG_ORIGIN_X: plane_org[0] = sext_to(longint'(data), 32);
      REG_ORIGIN_Y: plane_org[1] = sext_to(longint'(data), 32);
      REG_ORIGIN_Z: plane_org[2] = sext_to(longint'(data), 32);
      REG_NORMAL_X: plane_nrm[0] = sext_to(longint'(data), 18);
      REG_NORMAL_Y: plane_nrm[1] = sext_to(longint'(data), 18);
      REG_NORMAL_Z: plane_nrm[2] = sext_to(longint'(data), 18);
      REG_PLANE_TOL: on_plane_tol = longint'(data[15:0]);
      REG_POINT_TOL: same_pt_tol = longint'(data[15:0]);
      default: ;
    endcase
  endfunction

  function automatic longint abs_l(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint plane_dist(point_t p);
    longint sum;
    sum = 0;
    for (int j = 0; j < 3; j++) sum += (longint'(p[j]) - plane_org[j]) * plane_nrm[j];
    return (sum + 32768) >>> 16;
  endfunction

  function automatic void keep_point(longint p0, longint p1, longint p2);
    bit dup;
    if (sec_cnt >= 2) return;
    for (int i = 0; i < sec_cnt; i++) begin
      dup = abs_l(sec_pts[i][0] - p0) <= same_pt_tol && abs_l(sec_pts[i][1] - p1) <= same_pt_tol
            && abs_l(sec_pts[i][2] - p2) <= same_pt_tol;
      if (dup) return;
    end
    sec_pts[sec_cnt][0] = p0;
    sec_pts[sec_cnt][1] = p1;
    sec_pts[sec_cnt][2] = p2;
    sec_cnt++;
  endfunction

  function automatic void walk_edge(point_t a, point_t b, longint da, longint db);
    longint s, rem, q, t, px[3];
    if (abs_l(da) <= on_plane_tol) keep_point(a[0], a[1], a[2]);
    if (abs_l(db) <= on_plane_tol) keep_point(b[0], b[1], b[2]);
    if ((da < -on_plane_tol && db > on_plane_tol) || (da > on_plane_tol && db < -on_plane_tol)) begin
      s = abs_l(da) + abs_l(db);
      rem = abs_l(da);
      q = 0;
      for (int i = 0; i < 31; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= s) begin
          rem -= s;
          q |= 1;
        end
      end
      t = (q + 1) >> 1;
      // |b - a| < 2^32 and t <= 2^30, so the product stays inside 64 bits.
      for (int j = 0; j < 3; j++)
        px[j] = longint'(a[j]) + (((longint'(b[j]) - longint'(a[j])) * t + (longint'(1) << 29)) >>> 30);
      keep_point(px[0], px[1], px[2]);
    end
  endfunction

  function automatic bit section_of(point_t a, point_t b, point_t c, output seg_t s);
    longint da, db, dc;
    da = plane_dist(a);
    db = plane_dist(b);
    dc = plane_dist(c);
    sec_cnt = 0;
    walk_edge(a, b, da, db);
    walk_edge(b, c, db, dc);
    walk_edge(c, a, dc, da);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 3; j++) s[i * 3 + j] = coord_t'(sec_pts[i][j]);
    return sec_cnt >= 2;
  endfunction

  function automatic void expect_seg(seg_t s);
    pending_segs.insert(pending_segs.size(), s);
  endfunction

  // Called at a falling edge; returns at the falling edge after the triangle is taken.
  task automatic send_triangle(point_t a, point_t b, point_t c, chk_e chk, seg_t lit);
    seg_t s;
    while (!quiet_stretch && $urandom_range(0, 99) < 12) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    va = a;
    vb = b;
    vc = c;
    do @(posedge clk_i); while (busy_o);
    triangles_sent++;
    if (chk == CHK_SEGMENT) expect_seg(lit);
    else if (chk == CHK_PREDICT && section_of(a, b, c, s)) expect_seg(s);
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    store_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic load_plane(longint ox, longint oy, longint oz, longint nx, longint ny,
                            longint nz, longint ptol, longint qtol);
    start_i = 1'b0;
    wait (pending_segs.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    write_reg(REG_ORIGIN_X, 32'(ox));
    write_reg(REG_ORIGIN_Y, 32'(oy));
    write_reg(REG_ORIGIN_Z, 32'(oz));
    write_reg(REG_NORMAL_X, 32'(nx));
    write_reg(REG_NORMAL_Y, 32'(ny));
    write_reg(REG_NORMAL_Z, 32'(nz));
    write_reg(REG_PLANE_TOL, 32'(ptol));
    write_reg(REG_POINT_TOL, 32'(qtol));
    cfg_valid_i = 1'b0;
  endtask

  function automatic coord_t near_coord(longint center, int w);
    longint off;
    off = longint'($signed($urandom)) >>> (32 - w);
    return coord_t'(center + off);
  endfunction

  task automatic random_triangles(int n);
    point_t p[3];
    int w, mode;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(0, 99);
      w = $urandom_range(1, 32);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p[i][j] = (mode < 10) ? coord_t'($urandom) : near_coord(plane_org[j], w);
      if (mode >= 10) begin
        // Vertices on the origin lie on the plane; repeated vertices exercise dedup.
        for (int i = 0; i < 3; i++)
          if ($urandom_range(0, 99) < 12)
            for (int j = 0; j < 3; j++) p[i][j] = coord_t'(plane_org[j]);
        if ($urandom_range(0, 99) < 8) p[1] = p[0];
        if ($urandom_range(0, 99) < 8) p[2] = p[$urandom_range(0, 1)];
      end
      send_triangle(p[0], p[1], p[2], CHK_PREDICT, '0);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && seg_valid_o) begin
      segs_seen++;
      if (pending_segs.size() == 0) begin
        $error("segment beat with nothing expected");
        errors++;
      end else begin
        automatic seg_t want = pending_segs.pop_front();
        automatic string fld[6] = '{"seg_start_x", "seg_start_y", "seg_start_z",
                                    "seg_end_x", "seg_end_y", "seg_end_z"};
        for (int i = 0; i < 6; i++)
          if (seg_out[i] !== want[i]) begin
            $error("%s: expected %0d, got %0d", fld[i], want[i], seg_out[i]);
            errors++;
          end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_triangle_plane_section: done, errors");
      $finish;
    end
  end

  localparam longint ONE = 65536;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;

  function automatic point_t pt(longint x, longint y, longint z);
    return {coord_t'(z), coord_t'(y), coord_t'(x)};
  endfunction

  initial begin
    tri_row_t rows[$];
    tri_row_t r;

    plane_org = '{0, 0, 0};
    plane_nrm = '{0, 0, ONE};
    on_plane_tol = 1;
    same_pt_tol = 1;

    // Reset plane: z = 0, tolerances of one LSB.
    r = '{pt(0, 0, 0), pt(ONE, 0, 0), pt(0, ONE, ONE), CHK_SEGMENT, '0};
    r.seg = {coord_t'(0), coord_t'(0), coord_t'(ONE), coord_t'(0), coord_t'(0), coord_t'(0)};
    rows.insert(rows.size(), r);
    r = '{pt(0, 0, -ONE), pt(0, 0, ONE), pt(ONE, 0, ONE), CHK_SEGMENT, '0};
    r.seg = {coord_t'(0), coord_t'(0), coord_t'(ONE / 2), coord_t'(0), coord_t'(0), coord_t'(0)};
    rows.insert(rows.size(), r);
    r = '{pt(0, 0, ONE), pt(5, 7, 2 * ONE), pt(-3, 1, 3), CHK_NONE, '0};
    rows.insert(rows.size(), r);
    r = '{pt(0, 0, -ONE), pt(5, 7, -2), pt(-3, 1, CMIN), CHK_NONE, '0};
    rows.insert(rows.size(), r);
    r = '{pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), CHK_NONE, '0};
    rows.insert(rows.size(), r);
    r = '{pt(0, 0, 0), pt(0, 0, 0), pt(ONE, 0, 0), CHK_SEGMENT, '0};
    r.seg = {coord_t'(0), coord_t'(0), coord_t'(ONE), coord_t'(0), coord_t'(0), coord_t'(0)};
    rows.insert(rows.size(), r);
    r = '{pt(CMAX, CMAX, CMAX), pt(CMIN, CMIN, CMIN), pt(0, CMIN, CMAX), CHK_PREDICT, '0};
    rows.insert(rows.size(), r);
    r = '{pt(CMIN, CMAX, CMIN), pt(CMAX, CMIN, CMAX), pt(CMAX, CMAX, CMIN), CHK_PREDICT, '0};
    rows.insert(rows.size(), r);
    r = '{pt(0, 0, 1), pt(5, 0, 2), pt(9, 9, -2), CHK_PREDICT, '0};
    rows.insert(rows.size(), r);
    r = '{pt(0, 0, 0), pt(1, 1, 1), pt(10, 10, -ONE), CHK_PREDICT, '0};
    rows.insert(rows.size(), r);
    r = '{pt(3, 4, 0), pt(7, -9, 5 * ONE), pt(-ONE, 12, -3 * ONE), CHK_PREDICT, '0};
    rows.insert(rows.size(), r);
    r = '{pt(-1, -1, -1), pt(1, 1, 1), pt(0, 0, 0), CHK_PREDICT, '0};
    rows.insert(rows.size(), r);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_triangle(rows[i].a, rows[i].b, rows[i].c, rows[i].chk, rows[i].seg);
    random_triangles(RAND_PER_PHASE);

    load_plane($signed($urandom), $signed($urandom), $signed($urandom),
               $urandom_range(0, 131072) - ONE, $urandom_range(0, 131072) - ONE,
               $urandom_range(0, 131072) - ONE, $urandom_range(0, 65535),
               $urandom_range(0, 65535));
    random_triangles(RAND_PER_PHASE);

    quiet_stretch = 1'b1;
    load_plane(CMAX, CMAX, CMAX, -ONE, -ONE, -ONE, 65535, 65535);
    random_triangles(RAND_PER_PHASE);
    quiet_stretch = 1'b0;

    load_plane(CMIN, CMIN, CMIN, ONE, ONE, ONE, 0, 0);
    random_triangles(RAND_PER_PHASE);

    // With a zero normal every vertex is on the plane.
    load_plane($signed($urandom), 0, -ONE, 0, 0, 0, $urandom_range(0, 65535),
               $urandom_range(0, 16));
    random_triangles(RAND_PER_PHASE / 2);

    // Raw 18-bit normals, far from unit length, with junk in the upper data bits.
    load_plane(0, ONE, -ONE, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_triangles(RAND_PER_PHASE);

    load_plane($signed($urandom) >>> 12, $signed($urandom) >>> 12, 0, 0, ONE, 0,
               $urandom_range(0, 8), $urandom_range(0, 8));
    random_triangles(RAND_PER_PHASE);

    start_i = 1'b0;
    wait (pending_segs.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d triangles sent over seven plane settings, %0d segments checked",
             triangles_sent, segs_seen);
    if (errors == 0) begin
      $display("tb_triangle_plane_section: done, clean");
    end else begin
      $display("tb_triangle_plane_section: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tps_pkg.sv
rtl/tps_div_stage.sv
rtl/triangle_plane_section.sv
tb/tb_triangle_plane_section.sv
